// ===== sv/dsmm_pkg.sv =====
package dsmm_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_FACTOR = 8;
    localparam int DATA_W         = 32;
    localparam int ROUND_OFFSET   = 26214;
    localparam int CFG_IDX_W      = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FACTOR    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_METHOD    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 3'd5;

    localparam logic METHOD_MEAN = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WALK,
        ST_WTAIL,
        ST_DECIDE,
        ST_DIV,
        ST_DIV_WAIT,
        ST_M_RD,
        ST_M_RND,
        ST_M_CMP,
        ST_M_NEW,
        ST_M_SCAN,
        ST_M_BEST,
        ST_DONE
    } t_state;

endpackage

// ===== sv/dsmm_ram.sv =====
module dsmm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/dsmm_div.sv =====
module dsmm_div #(
    parameter int NW = 38,
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quo
);

    localparam int CNTW = $clog2(NW + 1);

    logic [DW:0]     r_rem, n_rem;
    logic [NW-1:0]   r_quo, n_quo;
    logic [DW-1:0]   r_den, n_den;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic            r_busy, n_busy;
    logic            r_done, n_done;
    logic [DW:0]     rem_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
        r_cnt <= n_cnt;
    end

    // restoring division, one quotient bit per cycle
    always_comb begin
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        rem_sh = {r_rem[DW-1:0], r_quo[NW-1]};
        if (i_start) begin
            n_rem  = '0;
            n_quo  = i_num;
            n_den  = i_den;
            n_cnt  = CNTW'(NW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (rem_sh >= {1'b0, r_den}) begin
                n_rem = rem_sh - {1'b0, r_den};
                n_quo = {r_quo[NW-2:0], 1'b1};
            end else begin
                n_rem = rem_sh;
                n_quo = {r_quo[NW-2:0], 1'b0};
            end
            n_cnt = r_cnt - CNTW'(1);
            if (r_cnt == CNTW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ===== sv/block_downsample_mean_mode.sv =====
// Block downsampler: signed Q16.16 samples enter in row order and every N by N window
// (edges clamped) gives one pixel: fill value if any sample lies within the tolerance of
// it, else the truncated mean or the first-seen mode of the rounded samples. A sample that
// closes no window leaves the block ready for the next. A closing sample holds off input
// while a small sequencer walks the window through the single band memory read port, then
// runs the bit-serial divider (mean), or builds the mode's value list in a scratch memory
// that is scanned per sample.
module block_downsample_mean_mode
    import dsmm_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_FACTOR = DEF_MAX_FACTOR
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [31:0]   i_sample,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [31:0]   o_pixel_value,
    output logic                 o_last_of_frame
);

    localparam int XW   = $clog2(MAX_WIDTH);
    localparam int WEW  = $clog2(MAX_WIDTH + 1);
    localparam int CW   = $clog2(MAX_FACTOR + 1);
    localparam int BD   = MAX_WIDTH * MAX_FACTOR;
    localparam int BAW  = $clog2(BD);
    localparam int WM   = MAX_FACTOR * MAX_FACTOR;
    localparam int UAW  = (WM > 1) ? $clog2(WM) : 1;
    localparam int UCW  = $clog2(WM + 1);
    localparam int SW   = 33 + 2 * $clog2(MAX_FACTOR);
    localparam int KW   = 17;
    localparam int UW   = KW + UCW;

    // configuration
    logic [10:0] r_cfg_w;
    logic [15:0] r_cfg_h;
    logic [3:0]  r_cfg_n;
    logic        r_cfg_m;
    logic [31:0] r_cfg_fill;
    logic [30:0] r_cfg_tol;
    logic        cfg_hit;

    logic [WEW-1:0] weff;
    logic [15:0]    heff;
    logic [CW-1:0]  neff;

    // frame position
    logic [XW-1:0] r_col, n_col;
    logic [15:0]   r_row, n_row;
    logic [CW-1:0] r_cmod, n_cmod, r_rmod, n_rmod;

    t_state r_state, n_state;

    // window context
    logic [XW-1:0]  r_wc, n_wc;
    logic [CW-1:0]  r_wcm, n_wcm, r_wrm, n_wrm;
    logic           r_wlast, n_wlast;
    logic [CW-1:0]  r_ii, n_ii, r_jj, n_jj;
    logic           r_pv, n_pv;
    logic signed [SW-1:0] r_sum, n_sum;
    logic           r_miss, n_miss;
    logic [31:0]    r_res, n_res;

    // mode scratch
    logic signed [KW-1:0] r_k, n_k, r_bk, n_bk;
    logic [UCW-1:0] r_bc, n_bc, r_used, n_used, r_j, n_j;

    // output register
    logic        r_out_vld, n_out_vld;
    logic [31:0] r_out_pix, n_out_pix;
    logic        r_out_last, n_out_last;

    // band memory
    logic           b_we;
    logic [BAW-1:0] b_waddr, b_raddr;
    logic [31:0]    b_rdata;

    // scratch memory
    logic           u_we;
    logic [UAW-1:0] u_waddr, u_raddr;
    logic [UW-1:0]  u_wdata, u_rdata;

    // divider
    logic           d_start, d_done;
    logic [SW-1:0]  d_num, d_quo;
    logic [2*CW-1:0] d_den;

    logic           accept, emit, col_end, row_end, win_end;
    logic [CW-1:0]  bank, cofs;
    logic [XW-1:0]  rd_col;
    logic signed [32:0] diff, absd, kx;
    logic signed [KW-1:0] kval;
    logic signed [KW-1:0] uk;
    logic [UCW-1:0] uc;
    logic [SW-1:0]  mag;

    assign accept = i_valid && o_ready;
    assign o_ready = (r_state == ST_IDLE);
    assign cfg_hit = i_cfg_we && (i_cfg_idx <= CFG_TOLERANCE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w    <= 11'd1;
            r_cfg_h    <= 16'd1;
            r_cfg_n    <= 4'd2;
            r_cfg_m    <= 1'b0;
            r_cfg_fill <= '0;
            r_cfg_tol  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WIDTH:     r_cfg_w    <= i_cfg_data[10:0];
                CFG_HEIGHT:    r_cfg_h    <= i_cfg_data[15:0];
                CFG_FACTOR:    r_cfg_n    <= i_cfg_data[3:0];
                CFG_METHOD:    r_cfg_m    <= i_cfg_data[0];
                CFG_FILL:      r_cfg_fill <= i_cfg_data;
                CFG_TOLERANCE: r_cfg_tol  <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_cfg_w == 11'd0) begin
            weff = WEW'(1);
        end else if (32'(r_cfg_w) > MAX_WIDTH) begin
            weff = WEW'(MAX_WIDTH);
        end else begin
            weff = WEW'(r_cfg_w);
        end
        heff = (r_cfg_h == 16'd0) ? 16'd1 : r_cfg_h;
        if (r_cfg_n == 4'd0) begin
            neff = CW'(1);
        end else if (32'(r_cfg_n) > MAX_FACTOR) begin
            neff = CW'(MAX_FACTOR);
        end else begin
            neff = CW'(r_cfg_n);
        end
    end

    assign col_end = (WEW'(r_col) == weff - WEW'(1));
    assign row_end = (r_row == heff - 16'd1);
    assign emit    = (r_rmod == neff - CW'(1) || row_end)
                  && (r_cmod == neff - CW'(1) || col_end);
    assign win_end = (r_ii == neff - CW'(1)) && (r_jj == neff - CW'(1));

    // clamped window address: rows past the bottom map to the current bank
    assign bank    = (r_jj > r_wrm) ? r_wrm : r_jj;
    assign cofs    = (r_ii > r_wcm) ? r_wcm : r_ii;
    assign rd_col  = r_wc - XW'(r_wcm) + XW'(cofs);
    assign b_raddr = BAW'(bank * MAX_WIDTH) + BAW'(rd_col);
    assign b_waddr = BAW'(r_rmod * MAX_WIDTH) + BAW'(r_col);
    assign b_we    = accept;

    assign diff = 33'(signed'(b_rdata)) - 33'(signed'(r_cfg_fill));
    assign absd = diff[32] ? -diff : diff;
    assign kx   = signed'(b_rdata) > 0 ? 33'(signed'(b_rdata)) + 33'(ROUND_OFFSET)
                                       : -33'(signed'(b_rdata)) + 33'(ROUND_OFFSET);
    assign kval = signed'(b_rdata) > 0 ? KW'(kx >>> 16) : -KW'(kx >>> 16);

    assign uk = signed'(u_rdata[UW-1:UCW]);
    assign uc = u_rdata[UCW-1:0];

    assign mag     = r_sum[SW-1] ? SW'(-r_sum) : SW'(r_sum);
    assign d_num   = mag;
    assign d_den   = (2*CW)'(neff) * (2*CW)'(neff);
    assign u_raddr = n_j[UAW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_col     <= '0;
            r_row     <= '0;
            r_cmod    <= '0;
            r_rmod    <= '0;
            r_out_vld <= 1'b0;
            r_pv      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_col     <= n_col;
            r_row     <= n_row;
            r_cmod    <= n_cmod;
            r_rmod    <= n_rmod;
            r_out_vld <= n_out_vld;
            r_pv      <= n_pv;
        end
        r_wc       <= n_wc;
        r_wcm      <= n_wcm;
        r_wrm      <= n_wrm;
        r_wlast    <= n_wlast;
        r_ii       <= n_ii;
        r_jj       <= n_jj;
        r_sum      <= n_sum;
        r_miss     <= n_miss;
        r_res      <= n_res;
        r_k        <= n_k;
        r_bk       <= n_bk;
        r_bc       <= n_bc;
        r_used     <= n_used;
        r_j        <= n_j;
        r_out_pix  <= n_out_pix;
        r_out_last <= n_out_last;
    end

    always_comb begin
        n_state    = r_state;
        n_col      = r_col;
        n_row      = r_row;
        n_cmod     = r_cmod;
        n_rmod     = r_rmod;
        n_wc       = r_wc;
        n_wcm      = r_wcm;
        n_wrm      = r_wrm;
        n_wlast    = r_wlast;
        n_ii       = r_ii;
        n_jj       = r_jj;
        n_pv       = 1'b0;
        n_sum      = r_sum;
        n_miss     = r_miss;
        n_res      = r_res;
        n_k        = r_k;
        n_bk       = r_bk;
        n_bc       = r_bc;
        n_used     = r_used;
        n_j        = r_j;
        n_out_vld  = r_out_vld && !i_ready;
        n_out_pix  = r_out_pix;
        n_out_last = r_out_last;
        d_start    = 1'b0;
        u_we       = 1'b0;
        u_waddr    = r_j[UAW-1:0];
        u_wdata    = {r_k, uc + UCW'(1)};

        if (r_pv) begin
            n_sum = r_sum + SW'(signed'(b_rdata));
            if (absd <= 33'(r_cfg_tol)) begin
                n_miss = 1'b1;
            end
        end

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_wc    = r_col;
                    n_wcm   = r_cmod;
                    n_wrm   = r_rmod;
                    n_wlast = row_end && col_end;
                    n_ii    = '0;
                    n_jj    = '0;
                    n_sum   = '0;
                    n_miss  = 1'b0;
                    if (emit) begin
                        n_state = ST_WALK;
                    end
                    if (col_end) begin
                        n_col  = '0;
                        n_cmod = '0;
                        if (row_end) begin
                            n_row  = '0;
                            n_rmod = '0;
                        end else begin
                            n_row  = r_row + 16'd1;
                            n_rmod = (r_rmod == neff - CW'(1)) ? '0 : r_rmod + CW'(1);
                        end
                    end else begin
                        n_col  = r_col + XW'(1);
                        n_cmod = (r_cmod == neff - CW'(1)) ? '0 : r_cmod + CW'(1);
                    end
                end
            end
            ST_WALK: begin
                n_pv = 1'b1;
                if (win_end) begin
                    n_state = ST_WTAIL;
                end else if (r_ii == neff - CW'(1)) begin
                    n_ii = '0;
                    n_jj = r_jj + CW'(1);
                end else begin
                    n_ii = r_ii + CW'(1);
                end
            end
            ST_WTAIL: begin
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                n_ii = '0;
                n_jj = '0;
                if (r_miss) begin
                    n_res   = r_cfg_fill;
                    n_state = ST_DONE;
                end else if (r_cfg_m == METHOD_MEAN) begin
                    d_start = 1'b1;
                    n_state = ST_DIV;
                end else begin
                    n_used  = '0;
                    n_j     = '0;
                    n_state = ST_M_RD;
                end
            end
            ST_DIV: begin
                n_state = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (d_done) begin
                    n_res   = r_sum[SW-1] ? 32'(-d_quo) : 32'(d_quo);
                    n_state = ST_DONE;
                end
            end
            ST_M_RD: begin
                n_state = ST_M_RND;
            end
            ST_M_RND: begin
                n_k = kval;
                n_j = '0;
                n_state = (r_used == '0) ? ST_M_NEW : ST_M_CMP;
            end
            ST_M_CMP: begin
                if (uk == r_k) begin
                    u_we = 1'b1;
                    if (win_end) begin
                        n_j     = '0;
                        n_state = ST_M_SCAN;
                    end else begin
                        n_state = ST_M_RD;
                        if (r_ii == neff - CW'(1)) begin
                            n_ii = '0;
                            n_jj = r_jj + CW'(1);
                        end else begin
                            n_ii = r_ii + CW'(1);
                        end
                    end
                end else begin
                    n_j = r_j + UCW'(1);
                    if (n_j == r_used) begin
                        n_state = ST_M_NEW;
                    end
                end
            end
            ST_M_NEW: begin
                u_we    = 1'b1;
                u_waddr = r_used[UAW-1:0];
                u_wdata = {r_k, UCW'(1)};
                n_used  = r_used + UCW'(1);
                if (win_end) begin
                    n_j     = '0;
                    n_state = ST_M_SCAN;
                end else begin
                    n_state = ST_M_RD;
                    if (r_ii == neff - CW'(1)) begin
                        n_ii = '0;
                        n_jj = r_jj + CW'(1);
                    end else begin
                        n_ii = r_ii + CW'(1);
                    end
                end
            end
            ST_M_SCAN: begin
                // first entry is read only after the last count update has landed
                n_j     = '0;
                n_state = ST_M_BEST;
            end
            ST_M_BEST: begin
                // strict compare keeps the first-seen value on ties
                if (r_j == '0 || uc > r_bc) begin
                    n_bk = uk;
                    n_bc = uc;
                end
                n_j = r_j + UCW'(1);
                if (n_j == r_used) begin
                    n_res   = (n_bk >= KW'(32768)) ? 32'h7FFF_FFFF : {n_bk[15:0], 16'h0000};
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_vld || i_ready) begin
                    n_out_vld  = 1'b1;
                    n_out_pix  = r_res;
                    n_out_last = r_wlast;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        // any register write restarts the frame
        if (cfg_hit) begin
            n_col  = '0;
            n_row  = '0;
            n_cmod = '0;
            n_rmod = '0;
        end
    end

    dsmm_ram #(
        .WIDTH(32),
        .DEPTH(BD),
        .AW   (BAW)
    ) u_band (
        .i_clk  (i_clk),
        .i_we   (b_we),
        .i_waddr(b_waddr),
        .i_wdata(i_sample),
        .i_raddr(b_raddr),
        .o_rdata(b_rdata)
    );

    dsmm_ram #(
        .WIDTH(UW),
        .DEPTH(WM),
        .AW   (UAW)
    ) u_uniq (
        .i_clk  (i_clk),
        .i_we   (u_we),
        .i_waddr(u_waddr),
        .i_wdata(u_wdata),
        .i_raddr(u_raddr),
        .o_rdata(u_rdata)
    );

    dsmm_div #(
        .NW(SW),
        .DW(2*CW)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(d_start),
        .i_num  (d_num),
        .i_den  (d_den),
        .o_done (d_done),
        .o_quo  (d_quo)
    );

    assign o_valid         = r_out_vld;
    assign o_pixel_value   = signed'(r_out_pix);
    assign o_last_of_frame = r_out_last;

endmodule

// ===== tb/block_downsample_mean_mode_tb.sv =====
`timescale 1ns / 1ps

module block_downsample_mean_mode_tb;
    import dsmm_pkg::*;

    localparam int  MAXW        = 1024;
    localparam int  MAXF        = 8;
    localparam int  RND_OFS     = 26214;
    localparam int  RANDOM_GOAL = 900;
    localparam int  DRAIN_GAP   = 40;
    localparam longint CYCLE_LIMIT = 20000000;

    typedef struct packed {
        logic signed [31:0] value;
        logic               last;
    } pixel_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [31:0]          i_cfg_data;
    logic                 i_valid;
    logic                 o_ready;
    logic signed [31:0]   i_sample;
    logic                 o_valid;
    logic                 i_ready;
    logic signed [31:0]   o_pixel_value;
    logic                 o_last_of_frame;

    block_downsample_mean_mode u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_sample        (i_sample),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_pixel_value   (o_pixel_value),
        .o_last_of_frame (o_last_of_frame)
    );

    // shadow copy of the block state
    logic [10:0]        cfg_width;
    logic [15:0]        cfg_height;
    logic [3:0]         cfg_factor;
    logic               cfg_method;
    logic signed [31:0] cfg_fill;
    logic [30:0]        cfg_tol;
    logic signed [31:0] band_mem [0:MAXW*MAXF-1];
    int unsigned        col_pos;
    int unsigned        row_pos;

    logic signed [31:0] sample_q [$];
    pixel_t             pixel_q  [$];
    int                 send_idle_pct;
    int                 recv_idle_pct;
    int                 err_count;
    int                 pixels_checked;
    int                 samples_sent;
    int                 phase_count;
    longint             cycle_count;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic longint round_to_int(longint x);
        if (x > 0)
            return (x + RND_OFS) / 65536;
        return -((-x + RND_OFS) / 65536);
    endfunction

    function automatic logic signed [31:0] window_mode(longint vals[64], int cnt);
        longint uniq [64];
        int     hits [64];
        int     used;
        int     best;
        longint k;
        bit     found;
        used = 0;
        best = 0;
        for (int i = 0; i < cnt; i++) begin
            k = round_to_int(vals[i]);
            found = 0;
            for (int j = 0; j < used; j++) begin
                if (!found && uniq[j] == k) begin
                    hits[j]++;
                    found = 1;
                end
            end
            if (!found) begin
                uniq[used] = k;
                hits[used] = 1;
                used++;
            end
        end
        for (int j = 1; j < used; j++)
            if (hits[j] > hits[best])
                best = j;
        if (uniq[best] >= 32768)
            return 32'sh7FFFFFFF;
        return 32'(uniq[best] * 65536);
    endfunction

    task automatic shrink_sample(logic signed [31:0] smp);
        int unsigned w, h, n, c, r, i0, j0, rr, cc, cnt;
        longint      vals [64];
        longint      sum, gap, fill;
        bit          missing;
        pixel_t      px;
        w = cfg_width;
        h = cfg_height;
        n = cfg_factor;
        if (w == 0) w = 1;
        if (w > MAXW) w = MAXW;
        if (h == 0) h = 1;
        if (n == 0) n = 1;
        if (n > MAXF) n = MAXF;
        c = (col_pos >= w) ? 0 : col_pos;
        r = (row_pos >= h) ? 0 : row_pos;
        fill = longint'(cfg_fill);
        band_mem[(r % n) * MAXW + c] = smp;
        if ((r % n == n - 1 || r == h - 1) && (c % n == n - 1 || c == w - 1)) begin
            i0 = c - c % n;
            j0 = r - r % n;
            cnt = 0;
            missing = 0;
            sum = 0;
            for (int jj = 0; jj < n; jj++) begin
                rr = (j0 + jj > h - 1) ? h - 1 : j0 + jj;
                for (int ii = 0; ii < n; ii++) begin
                    cc = (i0 + ii > w - 1) ? w - 1 : i0 + ii;
                    vals[cnt] = longint'(band_mem[(rr % n) * MAXW + cc]);
                    gap = vals[cnt] - fill;
                    if (gap < 0) gap = -gap;
                    if (gap <= longint'(cfg_tol)) missing = 1;
                    sum += vals[cnt];
                    cnt++;
                end
            end
            if (missing)
                px.value = cfg_fill;
            else if (cfg_method == METHOD_MEAN)
                px.value = 32'(sum / longint'(cnt));
            else
                px.value = window_mode(vals, cnt);
            px.last = (r == h - 1 && c == w - 1);
            pixel_q.push_back(px);
        end
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        col_pos = c;
        row_pos = r;
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            i_sample <= '0;
        end else begin
            if (i_valid && o_ready) begin
                shrink_sample(i_sample);
                samples_sent++;
            end
            if (!i_valid || o_ready) begin
                if (sample_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_valid  <= 1'b1;
                    i_sample <= sample_q.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        pixel_t px;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            if (o_valid && i_ready) begin
                if (pixel_q.size() == 0) begin
                    $error("unexpected pixel transaction: value %h last %b",
                           o_pixel_value, o_last_of_frame);
                    err_count++;
                end else begin
                    px = pixel_q.pop_front();
                    pixels_checked++;
                    if (o_pixel_value !== px.value) begin
                        $error("pixel_value: expected %h actual %h", px.value, o_pixel_value);
                        err_count++;
                    end
                    if (o_last_of_frame !== px.last) begin
                        $error("last_of_frame: expected %b actual %b",
                               px.last, o_last_of_frame);
                        err_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout with %0d pixels outstanding", pixel_q.size());
            $display("block_downsample_mean_mode regression: fail");
            $finish;
        end
    end

    task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_WIDTH:     cfg_width  = val[10:0];
            CFG_HEIGHT:    cfg_height = val[15:0];
            CFG_FACTOR:    cfg_factor = val[3:0];
            CFG_METHOD:    cfg_method = val[0];
            CFG_FILL:      cfg_fill   = val;
            CFG_TOLERANCE: cfg_tol    = val[30:0];
            default: ;
        endcase
        col_pos = 0;
        row_pos = 0;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // block is idle once nothing is queued, in flight or expected
    // checked mid-cycle so the edge updates have all settled
    task automatic wait_idle();
        while (sample_q.size() > 0 || i_valid || pixel_q.size() > 0)
            @(negedge i_clk);
        repeat (DRAIN_GAP) @(posedge i_clk);
    endtask

    task automatic setup(int w, int h, int n, int m, logic [31:0] f, logic [31:0] t);
        wait_idle();
        reg_write(CFG_WIDTH, w);
        reg_write(CFG_HEIGHT, h);
        reg_write(CFG_FACTOR, n);
        reg_write(CFG_METHOD, m);
        reg_write(CFG_FILL, f);
        reg_write(CFG_TOLERANCE, t);
        phase_count++;
    endtask

    function automatic logic signed [31:0] pick_sample();
        int frac;
        case ($urandom_range(0, 6))
            0: return $urandom;
            1: return cfg_fill + 32'(int'($urandom_range(0, 2000)) - 1000);
            2, 3: begin
                case ($urandom_range(0, 4))
                    0: frac = 0;
                    1: frac = 39321;
                    2: frac = 39322;
                    3: frac = 32768;
                    default: frac = $urandom_range(0, 65535);
                endcase
                return (int'($urandom_range(0, 6)) - 3) * 65536 + frac;
            end
            4: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
            default: return int'($urandom_range(0, 1310720)) - 655360;
        endcase
    endfunction

    initial begin
        int w, h, n, frame_len, total;
        logic [31:0] f, t;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_data     = '0;
        i_valid        = 1'b0;
        i_sample       = '0;
        i_ready        = 1'b0;
        cfg_width      = 11'd1;
        cfg_height     = 16'd1;
        cfg_factor     = 4'd2;
        cfg_method     = METHOD_MEAN;
        cfg_fill       = '0;
        cfg_tol        = '0;
        col_pos        = 0;
        row_pos        = 0;
        err_count      = 0;
        pixels_checked = 0;
        samples_sent   = 0;
        phase_count    = 0;
        cycle_count    = 0;
        send_idle_pct  = 12;
        recv_idle_pct  = 75;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: one-pixel frames, zero counts as missing
        sample_q.push_back(32'sh7FFFFFFF);
        sample_q.push_back(32'sh80000000);
        sample_q.push_back(32'sh00000000);
        sample_q.push_back(32'shFFFFFFFF);

        // tolerance at maximum, with fill and samples at opposite ends of the range
        setup(2, 2, 2, 0, 32'h80000000, 32'h7FFFFFFF);
        repeat (4) sample_q.push_back(32'sh7FFFFFFF);

        // mode saturation, rounding edges and ties
        setup(2, 2, 2, 1, 32'h80000000, 0);
        repeat (4) sample_q.push_back(32'sh7FFFFFFF);
        setup(0, 0, 0, 1, 32'h7FFFFFFF, 0);
        sample_q.push_back(32'sh8000_0001);
        sample_q.push_back(32'sh0000_9999);
        setup(2, 2, 2, 1, 32'h7FFFFFFF, 0);
        sample_q.push_back(32'sh0001_0000);
        sample_q.push_back(32'sh0002_0000);
        sample_q.push_back(32'sh0002_0000);
        sample_q.push_back(32'sh0000_999A);

        // oversized width and factor, abandoned partway by the next setup
        setup(2047, 3, 15, 0, 32'h7FFFFFFF, 0);
        repeat (20) sample_q.push_back(pick_sample());

        // tallest frame, one-row windows
        setup(1, 65535, 1, 1, 32'h12345678, 5);
        repeat (6) sample_q.push_back(pick_sample());

        total = 0;
        while (total < RANDOM_GOAL) begin
            if (total < RANDOM_GOAL / 3) begin
                send_idle_pct = 12;
                recv_idle_pct = 75;
            end else if (total < 2 * RANDOM_GOAL / 3) begin
                send_idle_pct = 75;
                recv_idle_pct = 12;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            w = $urandom_range(0, 30);
            h = $urandom_range(0, 12);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
            case ($urandom_range(0, 3))
                0: f = 32'h00000000;
                1: f = $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
                default: f = $urandom;
            endcase
            case ($urandom_range(0, 5))
                0: t = $urandom & 32'h7FFFFFFF;
                1, 2: t = $urandom_range(0, 2000);
                default: t = 0;
            endcase
            setup(w, h, n, $urandom_range(0, 1), f, t);
            frame_len = (w == 0 ? 1 : w) * (h == 0 ? 1 : h);
            if (frame_len > 150)
                frame_len = 150;
            repeat (frame_len) sample_q.push_back(pick_sample());
            total += frame_len;
        end

        wait_idle();
        repeat (200) @(posedge i_clk);
        $display("sent %0d samples over %0d register settings", samples_sent, phase_count);
        $display("checked %0d pixels, %0d mismatches", pixels_checked, err_count);
        if (err_count == 0 && pixel_q.size() == 0)
            $display("block_downsample_mean_mode regression: pass");
        else
            $display("block_downsample_mean_mode regression: fail");
        $finish;
    end

endmodule
